FILE: sv/world_to_screen_projection_macros.svh
// ----------------------------------------------------------------------------
// World-to-screen projection: assertion macros
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// next-cycle implication
`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define WSP_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants of the world-to-screen projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

    // fixed field widths
    localparam int COEF_W    = 32;
    localparam int POS_W     = 32;
    localparam int PIX_W     = 16;
    localparam int SIZE_W    = 14;
    localparam int HALF_W    = SIZE_W - 1;
    localparam int CLIP_W    = 64;
    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 3;

    localparam int FRAC_BITS_DEF = 16;

    // coefficient store
    localparam int MEM_DEPTH = 16;
    localparam int MEM_AW    = 4;

    // pixel divider
    localparam int QUO_W   = 17;
    localparam int DSH_W   = CLIP_W + QUO_W - 1;
    localparam int SAT_W   = CLIP_W + QUO_W;
    localparam int PROD_W  = HALF_W + QUO_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int CNT_W   = 5;
    localparam int HB_W    = $clog2(HALF_W);

    localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

    // register map
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd1080;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // item actions
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROJECT = 1'b1;

    // dot-product sequencing: 3 rows x 4 terms
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] MAC_STEPS = 4'd12;
    localparam logic [STEP_W-1:0] MAC_LAST  = 4'd11;
    localparam logic [1:0] K_TRANS = 2'd3;
    localparam logic [1:0] SLOT_X  = 2'd0;
    localparam logic [1:0] SLOT_Y  = 2'd1;
    localparam logic [1:0] SLOT_W  = 2'd2;
    localparam logic [1:0] ROW_CW  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_VIS,
        ST_X_START,
        ST_X_WAIT,
        ST_Y_START,
        ST_Y_WAIT,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [2:0] {
        PX_IDLE,
        PX_CHECK,
        PX_DIV,
        PX_FRAC_A,
        PX_FRAC_B,
        PX_MUL,
        PX_SUM,
        PX_DONE
    } pix_state_t;

    typedef struct packed {
        logic                     start;
        logic [HALF_W-1:0]        half;
        logic signed [CLIP_W-1:0] num;
        logic [CLIP_W-1:0]        den;
    } pix_req_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [PIX_W-1:0] value;
    } pix_rsp_t;

endpackage

`default_nettype wire

FILE: sv/wsp_coef_mem.sv
// ----------------------------------------------------------------------------
// wsp_coef_mem
// 16 x 32 coefficient RAM, one write and one registered read port; entries
// not yet written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_coef_mem
    import wsp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [MEM_AW-1:0]        waddr,
    input  logic [COEF_W-1:0]        wdata,
    input  logic                     re,
    input  logic [MEM_AW-1:0]        raddr,
    output logic signed [COEF_W-1:0] rdata
);

    logic [COEF_W-1:0]    coef_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [COEF_W-1:0]    rd_data_reg;
    logic                 rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            coef_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= coef_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_hit_reg <= valid_reg[raddr];
            end
        end
    end

    // unwritten entries read as zero through their cleared valid bits
    assign rdata = rd_hit_reg ? $signed(rd_data_reg) : '0;

endmodule

`default_nettype wire

FILE: sv/wsp_pixel_unit.sv
// ----------------------------------------------------------------------------
// wsp_pixel_unit
// Serial pixel mapper: trunc(half * num / den) saturated to 16 bits, den > 0.
// Bounded quotient by shift-subtract, then the fraction scaled by half.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_pixel_unit
    import wsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pix_req_t req,
    output pix_rsp_t rsp
);

    pix_state_t              state_reg, state_next;
    logic [HALF_W-1:0]       half_reg, half_next;
    logic                    neg_reg, neg_next;
    logic [CLIP_W-1:0]       rem_reg, rem_next;
    logic [CLIP_W-1:0]       den_reg, den_next;
    logic [DSH_W-1:0]        dsh_reg, dsh_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CLIP_W:0]         frem_reg, frem_next;
    logic [HALF_W-1:0]       fquo_reg, fquo_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [PIX_W-1:0] res_reg, res_next;

    logic [SAT_W-1:0]  sat_lim;
    logic [DSH_W-1:0]  div_diff;
    logic              div_ge;
    logic [CLIP_W:0]   frem_dbl;
    logic [CLIP_W:0]   frem_add;
    logic [SUM_W-1:0]  mag_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PX_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        half_reg <= half_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        frem_reg <= frem_next;
        fquo_reg <= fquo_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        half_next  = half_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        frem_next  = frem_reg;
        fquo_next  = fquo_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;

        // quotient above 65536 in magnitude iff |num| >= 65537 * den
        sat_lim  = (SAT_W'(den_reg) << (QUO_W - 1)) + SAT_W'(den_reg);
        div_ge   = DSH_W'(rem_reg) >= dsh_reg;
        div_diff = DSH_W'(rem_reg) - dsh_reg;
        frem_dbl = frem_reg << 1;
        frem_add = frem_reg + (CLIP_W + 1)'(rem_reg);
        mag_sum  = SUM_W'(prod_reg) + SUM_W'(fquo_reg);

        unique case (state_reg)
            PX_IDLE:
            begin
                if (req.start)
                begin
                    half_next = req.half;
                    neg_next  = req.num[CLIP_W-1];
                    rem_next  = req.num[CLIP_W-1] ? CLIP_W'(-req.num) : CLIP_W'(req.num);
                    den_next  = req.den;
                    if (req.half == '0)
                    begin
                        res_next   = '0;
                        state_next = PX_DONE;
                    end
                    else
                    begin
                        state_next = PX_CHECK;
                    end
                end
            end

            PX_CHECK:
            begin
                if (SAT_W'(rem_reg) >= sat_lim)
                begin
                    res_next   = neg_reg ? PIX_MIN : PIX_MAX;
                    state_next = PX_DONE;
                end
                else
                begin
                    dsh_next   = DSH_W'(den_reg) << (QUO_W - 1);
                    quo_next   = '0;
                    cnt_next   = CNT_W'(QUO_W - 1);
                    state_next = PX_DIV;
                end
            end

            PX_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = div_diff[CLIP_W-1:0];
                end
                quo_next = {quo_reg[QUO_W-2:0], div_ge};
                dsh_next = dsh_reg >> 1;
                if (cnt_reg == '0)
                begin
                    frem_next  = '0;
                    fquo_next  = '0;
                    cnt_next   = CNT_W'(HALF_W - 1);
                    state_next = PX_FRAC_A;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            // double the partial remainder
            PX_FRAC_A:
            begin
                if (frem_dbl >= (CLIP_W + 1)'(den_reg))
                begin
                    frem_next = frem_dbl - (CLIP_W + 1)'(den_reg);
                    fquo_next = {fquo_reg[HALF_W-2:0], 1'b1};
                end
                else
                begin
                    frem_next = frem_dbl;
                    fquo_next = {fquo_reg[HALF_W-2:0], 1'b0};
                end
                state_next = PX_FRAC_B;
            end

            // add the remainder where this bit of half is set
            PX_FRAC_B:
            begin
                if (half_reg[cnt_reg[HB_W-1:0]])
                begin
                    if (frem_add >= (CLIP_W + 1)'(den_reg))
                    begin
                        frem_next = frem_add - (CLIP_W + 1)'(den_reg);
                        fquo_next = fquo_reg + 1'b1;
                    end
                    else
                    begin
                        frem_next = frem_add;
                    end
                end
                if (cnt_reg == '0)
                begin
                    state_next = PX_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = PX_FRAC_A;
                end
            end

            PX_MUL:
            begin
                prod_next  = PROD_W'(half_reg) * PROD_W'(quo_reg);
                state_next = PX_SUM;
            end

            PX_SUM:
            begin
                if (neg_reg)
                begin
                    if (mag_sum > SUM_W'(32768))
                    begin
                        res_next = PIX_MIN;
                    end
                    else
                    begin
                        res_next = $signed(PIX_W'(0) - mag_sum[PIX_W-1:0]);
                    end
                end
                else
                begin
                    if (mag_sum > SUM_W'(32767))
                    begin
                        res_next = PIX_MAX;
                    end
                    else
                    begin
                        res_next = $signed(mag_sum[PIX_W-1:0]);
                    end
                end
                state_next = PX_DONE;
            end

            PX_DONE:
            begin
                state_next = PX_IDLE;
            end

            default:
            begin
                state_next = PX_IDLE;
            end
        endcase
    end

    assign rsp.busy  = (state_reg != PX_IDLE);
    assign rsp.done  = (state_reg == PX_DONE);
    assign rsp.value = res_reg;

endmodule

`default_nettype wire

FILE: sv/world_to_screen_projection.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection
// 4x4 view-projection of a fixed-point world point to pixel coordinates.
//
//   channel   direction  handshake          payload
//   in        in         in_valid/in_stall  action, coeff_index, coeff_value,
//                                           pos_x, pos_y, pos_z
//   out       out        out_valid/out_stall visible, screen_x, screen_y
//   config    in         APB write/read     screen_width, screen_height
//
// A load beat is written to the RAM as it is accepted. A project beat of a
// visible point runs 12 RAM reads through one multiplier, then two serial pixel
// divides; a point that is not visible skips the divides.
// The coefficient RAM reads as zero after reset; no clearing pass.
// in_stall is high from a project beat until its result enters the output
// register; the result register holds while out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "world_to_screen_projection_macros.svh"

module world_to_screen_projection
    import wsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     action,
    input  logic [MEM_AW-1:0]        coeff_index,
    input  logic signed [COEF_W-1:0] coeff_value,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     visible,
    output logic signed [PIX_W-1:0]  screen_x,
    output logic signed [PIX_W-1:0]  screen_y
);

    localparam logic signed [CLIP_W-1:0] VIS_ONE =
        {{(CLIP_W - 1){1'b0}}, 1'b1} << FRAC_BITS;

    ctl_state_t state_reg, state_next;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;

    logic [STEP_W-1:0] iss_cnt_reg;
    logic              p1_valid_reg;
    logic [STEP_W-1:0] p1_step_reg;
    logic              p2_valid_reg;
    logic [STEP_W-1:0] p2_step_reg;

    logic signed [CLIP_W-1:0] term_reg, term_next;
    logic signed [CLIP_W-1:0] acc_reg;
    logic signed [CLIP_W-1:0] cx_reg, cy_reg, cw_reg;

    logic signed [PIX_W-1:0] sx_reg, sy_reg;
    logic                    vis_reg;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_vis_reg;
    logic signed [PIX_W-1:0] out_x_reg, out_y_reg;

    logic                     cfg_we;
    logic                     in_take;
    logic                     mem_we;
    logic                     mem_re;
    logic [MEM_AW-1:0]        mem_raddr;
    logic [1:0]               iss_row;
    logic signed [COEF_W-1:0] coef_rd;
    logic signed [POS_W-1:0]  pos_sel;
    logic signed [CLIP_W-1:0] mult;
    logic signed [CLIP_W-1:0] acc_sum;
    logic signed [CLIP_W-1:0] cw_x10;
    logic                     vis_now;
    logic                     mac_last;
    logic                     out_load;

    pix_req_t px_req;
    pix_rsp_t px_rsp;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[PADDR_W-1])
                REG_WIDTH:  width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[SIZE_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[PADDR_W-1])
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign mem_we   = in_take && (action == ACT_LOAD);

    // ---------------------------------------------------------------- RAM
    assign mem_re    = (state_reg == ST_MAC) && (iss_cnt_reg != MAC_STEPS);
    assign iss_row   = (iss_cnt_reg[3:2] == SLOT_W) ? ROW_CW : iss_cnt_reg[3:2];
    assign mem_raddr = {iss_row, iss_cnt_reg[1:0]};

    wsp_coef_mem u_coef_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (coeff_index),
        .wdata (coeff_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (coef_rd)
    );

    // ---------------------------------------------------------------- MAC
    always_comb
    begin
        case (p1_step_reg[1:0])
            2'd0:    pos_sel = pos_x_reg;
            2'd1:    pos_sel = pos_y_reg;
            default: pos_sel = pos_z_reg;
        endcase
    end

    assign mult      = pos_sel * coef_rd;
    // floor the product by the fraction width; translation enters as is
    assign term_next = (p1_step_reg[1:0] == K_TRANS) ? CLIP_W'(coef_rd)
                                                     : (mult >>> FRAC_BITS);
    assign acc_sum   = acc_reg + term_reg;
    assign mac_last  = p2_valid_reg && (p2_step_reg == MAC_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_cnt_reg  <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                iss_cnt_reg <= '0;
            end
            else if (mem_re)
            begin
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
            end
            p1_valid_reg <= mem_re;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            pos_z_reg <= pos_z;
        end
        p1_step_reg <= iss_cnt_reg;
        p2_step_reg <= p1_step_reg;
        term_reg    <= term_next;

        if (in_take)
        begin
            acc_reg <= '0;
        end
        else if (p2_valid_reg)
        begin
            if (p2_step_reg[1:0] == K_TRANS)
            begin
                // close the row
                acc_reg <= '0;
                case (p2_step_reg[3:2])
                    SLOT_X:  cx_reg <= acc_sum;
                    SLOT_Y:  cy_reg <= acc_sum;
                    default: cw_reg <= acc_sum;
                endcase
            end
            else
            begin
                acc_reg <= acc_sum;
            end
        end
    end

    // ---------------------------------------------------------------- control
    assign cw_x10  = (cw_reg <<< 3) + (cw_reg <<< 1);
    assign vis_now = (cw_x10 >= VIS_ONE);

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        px_req.start   = 1'b0;
        px_req.half    = width_reg[SIZE_W-1:1];
        px_req.num     = cw_reg + cx_reg;
        px_req.den     = CLIP_W'(cw_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (action == ACT_PROJECT))
                begin
                    state_next = ST_MAC;
                end
            end

            ST_MAC:
            begin
                if (mac_last)
                begin
                    state_next = ST_VIS;
                end
            end

            ST_VIS:
            begin
                state_next = vis_now ? ST_X_START : ST_OUT;
            end

            ST_X_START:
            begin
                px_req.start = 1'b1;
                state_next   = ST_X_WAIT;
            end

            ST_X_WAIT:
            begin
                if (px_rsp.done)
                begin
                    state_next = ST_Y_START;
                end
            end

            ST_Y_START:
            begin
                px_req.start = 1'b1;
                px_req.half  = height_reg[SIZE_W-1:1];
                px_req.num   = cw_reg - cy_reg;
                state_next   = ST_Y_WAIT;
            end

            ST_Y_WAIT:
            begin
                if (px_rsp.done)
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    wsp_pixel_unit u_pixel_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (px_req),
        .rsp   (px_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_VIS)
        begin
            vis_reg <= vis_now;
            sx_reg  <= '0;
            sy_reg  <= '0;
        end
        if ((state_reg == ST_X_WAIT) && px_rsp.done)
        begin
            sx_reg <= px_rsp.value;
        end
        if ((state_reg == ST_Y_WAIT) && px_rsp.done)
        begin
            sy_reg <= px_rsp.value;
        end
        if (out_load)
        begin
            out_vis_reg <= vis_reg;
            out_x_reg   <= sx_reg;
            out_y_reg   <= sy_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = out_vis_reg;
    assign screen_x  = out_x_reg;
    assign screen_y  = out_y_reg;

    // ---------------------------------------------------------------- checks
    `WSP_ASSERT_IMPL(a_hidden_is_zero, clk, rst_n, out_valid_reg && !out_vis_reg, out_x_reg == '0 && out_y_reg == '0)
    `WSP_ASSERT_IMPL(a_read_in_mac, clk, rst_n, mem_re, state_reg == ST_MAC)
    `WSP_ASSERT_IMPL(a_px_start_idle, clk, rst_n, px_req.start, !px_rsp.busy)
    `WSP_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, mem_we, state_reg == ST_IDLE && !p1_valid_reg)

endmodule

`default_nettype wire
